### rtl/core/assert_macros.svh
// Assertion macros shared by the spline evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked at every rising clock edge.
`define CCR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication checked at every rising clock edge.
`define CCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/core/ccr_pkg.sv
// Types and constants of the Catmull-Rom spline evaluator.
package ccr_pkg;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_EVAL  = 1'b1;

   localparam logic REG_POINT_COUNT = 1'b0;

   localparam int MAX_POINTS = 16;

   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [16:0] HALF_Q16 = 17'd32768;

   localparam int AXIS_STAGES = 8;

   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_LINEAR,
      MODE_SPLINE
   } mode_type;

   typedef struct packed {
      logic              kind;
      logic [3:0]        point_index;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [16:0]       position;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] curve_x;
      logic signed [31:0] curve_y;
      logic signed [31:0] curve_z;
      logic              saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

endpackage

### rtl/core/catmull_rom_spline_eval_core.sv
// Evaluations pass the request, memory read and axis registers. Throughput: one item
// per cycle unless results stall, set by the fully pipelined multiply chain of each axis.
// Four copies of the point memory give the four point reads of an evaluation in one cycle.
// A result stall holds the whole pipeline; nothing is dropped or repeated.
// Synchronous reset clears point_count and all valid bits; point slots stay undefined.
`include "assert_macros.svh"
module catmull_rom_spline_eval_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ccr_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ccr_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import ccr_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   logic advance;
   logic [4:0] point_count_ff;

   logic [16:0] u;
   logic [4:0] n;
   logic [4:0] nm3;
   logic [21:0] s;
   logic [5:0] sg;
   logic [4:0] seg;
   mode_type a_mode_in;
   logic [16:0] a_weight_in;
   logic [4:0] a_base_in;

   logic a_valid_ff;
   logic a_kind_ff;
   logic [3:0] a_idx_ff;
   point_type a_point_ff;
   mode_type a_mode_ff;
   logic [16:0] a_weight_ff;
   logic [4:0] a_base_ff;

   logic b_valid_ff;
   mode_type b_mode_ff;
   logic [16:0] b_weight_ff;

   logic [AXIS_STAGES-1:0] v_ff;

   logic mem_we;
   point_type rd_pt [4];
   logic signed [31:0] val_x, val_y, val_z;
   logic sat_x, sat_y, sat_z;

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_POINT_COUNT) ? {27'd0, point_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_POINT_COUNT) begin
         point_count_ff <= csr_pwdata[4:0];
      end
   end

   always_comb begin
      u = (req_payload.position > ONE_Q16) ? ONE_Q16 : req_payload.position;
      n = (32'(point_count_ff) > MAX_POINTS) ? 5'(MAX_POINTS) : point_count_ff;
      nm3 = n - 5'd3;
      s = 22'(u) * 22'(nm3);
      sg = s[21:16];
      a_mode_in = MODE_ZERO;
      a_weight_in = '0;
      a_base_in = '0;
      seg = sg[4:0];
      if (n < 5'd2) begin
         a_mode_in = MODE_ZERO;
      end else if (n == 5'd2) begin
         a_mode_in = MODE_LINEAR;
         a_weight_in = u;
      end else if (n == 5'd3) begin
         a_mode_in = MODE_LINEAR;
         if (u < HALF_Q16) begin
            a_weight_in = 17'(u << 1);
         end else begin
            a_weight_in = 17'((u - HALF_Q16) << 1);
            a_base_in = 5'd1;
         end
      end else begin
         a_mode_in = MODE_SPLINE;
         if (sg >= {1'b0, nm3}) begin
            seg = n - 5'd4;
            a_weight_in = ONE_Q16;
         end else begin
            a_weight_in = {1'b0, s[15:0]};
         end
         a_base_in = seg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         v_ff <= '0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff && a_kind_ff == KIND_EVAL;
         v_ff <= {v_ff[AXIS_STAGES-2:0], b_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_kind_ff <= req_payload.kind;
         a_idx_ff <= req_payload.point_index;
         a_point_ff <= '{x: req_payload.point_x, y: req_payload.point_y,
                         z: req_payload.point_z};
         a_mode_ff <= a_mode_in;
         a_weight_ff <= a_weight_in;
         a_base_ff <= a_base_in;
         b_mode_ff <= a_mode_ff;
         b_weight_ff <= a_weight_ff;
      end
   end

   assign mem_we = advance && a_valid_ff && a_kind_ff == KIND_WRITE
                   && 32'(a_idx_ff) < MAX_POINTS;

   for (genvar k = 0; k < 4; k++) begin : g_bank
      ccr_point_mem #(
         .DEPTH(MAX_POINTS),
         .AW(AW)
      ) u_mem (
         .clock(clock),
         .wr_en(mem_we),
         .wr_addr(AW'(a_idx_ff)),
         .wr_data(a_point_ff),
         .rd_en(advance),
         .rd_addr(AW'(a_base_ff + 5'(k))),
         .rd_data(rd_pt[k])
      );
   end

   ccr_axis u_axis_x (
      .clock(clock), .advance(advance), .mode(b_mode_ff), .weight(b_weight_ff),
      .p0(rd_pt[0].x), .p1(rd_pt[1].x), .p2(rd_pt[2].x), .p3(rd_pt[3].x),
      .value(val_x), .sat(sat_x)
   );

   ccr_axis u_axis_y (
      .clock(clock), .advance(advance), .mode(b_mode_ff), .weight(b_weight_ff),
      .p0(rd_pt[0].y), .p1(rd_pt[1].y), .p2(rd_pt[2].y), .p3(rd_pt[3].y),
      .value(val_y), .sat(sat_y)
   );

   ccr_axis u_axis_z (
      .clock(clock), .advance(advance), .mode(b_mode_ff), .weight(b_weight_ff),
      .p0(rd_pt[0].z), .p1(rd_pt[1].z), .p2(rd_pt[2].z), .p3(rd_pt[3].z),
      .value(val_z), .sat(sat_z)
   );

   assign rsp_valid = v_ff[AXIS_STAGES-1];
   assign rsp_payload = '{curve_x: val_x, curve_y: val_y, curve_z: val_z,
                          saturated: sat_x | sat_y | sat_z};

   `CCR_ASSERT_NEXT(a_stall_holds_result, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `CCR_ASSERT_SAME(a_weight_in_range, clock, reset, a_valid_ff, a_weight_ff <= ONE_Q16)
   `CCR_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, !rsp_valid && !a_valid_ff)
   `CCR_ASSERT_SAME(a_no_write_on_stall, clock, reset, mem_we, !(rsp_valid && rsp_stall))

endmodule

### rtl/core/ccr_point_mem.sv
// Control point memory with one write port and one registered read port.
module ccr_point_mem #(
   parameter int DEPTH = 16,
   parameter int AW = 4
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  ccr_pkg::point_type      wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output ccr_pkg::point_type      rd_data
);
   import ccr_pkg::*;

   point_type mem_ff [DEPTH];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/ccr_axis.sv
// Pipelined Catmull-Rom and linear blend datapath for one coordinate.
module ccr_axis (
   input  logic                clock,
   input  logic                advance,
   input  ccr_pkg::mode_type   mode,
   input  logic [16:0]         weight,
   input  logic signed [31:0]  p0,
   input  logic signed [31:0]  p1,
   input  logic signed [31:0]  p2,
   input  logic signed [31:0]  p3,
   output logic signed [31:0]  value,
   output logic                sat
);
   import ccr_pkg::*;

   logic signed [35:0] e0, e1, e2, e3;
   logic signed [17:0] ws;

   mode_type c_mode_ff, d_mode_ff, e_mode_ff, f_mode_ff, g_mode_ff, h_mode_ff, i_mode_ff;
   logic [16:0] c_w_ff, d_w_ff, e_w_ff, f_w_ff, g_w_ff;
   logic signed [33:0] c_a_ff, d_a_ff, e_a_ff, f_a_ff, g_a_ff, h_a_ff;
   logic signed [32:0] c_b_ff, d_b_ff, e_b_ff, f_b_ff;
   logic signed [35:0] c_c_ff, d_c_ff;
   logic signed [34:0] c_d_ff;
   logic signed [32:0] c_diff_ff;
   logic signed [31:0] c_base_ff, d_base_ff;
   logic signed [52:0] d_m1_ff;
   logic signed [50:0] d_ml_ff;
   logic signed [36:0] e_h1_ff, g_h2_ff;
   logic signed [31:0] e_lin_ff, f_lin_ff, g_lin_ff, h_lin_ff, i_lin_ff;
   logic signed [54:0] f_m2_ff, h_m3_ff;
   logic signed [37:0] i_h3_ff;
   logic signed [31:0] value_ff;
   logic sat_ff;

   logic signed [35:0] c_c_in;
   logic signed [34:0] c_d_in;
   logic signed [52:0] m1_round;
   logic signed [50:0] ml_round;
   logic signed [54:0] m2_round, m3_round;
   logic signed [37:0] h3_round;
   logic signed [36:0] r_in;
   logic signed [31:0] value_in;
   logic sat_in;

   assign e0 = 36'(p0);
   assign e1 = 36'(p1);
   assign e2 = 36'(p2);
   assign e3 = 36'(p3);
   assign c_c_in = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
   assign c_d_in = 35'(e1 + (e1 <<< 1) - e2 - (e2 <<< 1) + e3 - e0);

   assign m1_round = d_m1_ff + 53'sd32768;
   assign ml_round = d_ml_ff + 51'sd32768;
   assign m2_round = f_m2_ff + 55'sd32768;
   assign m3_round = h_m3_ff + 55'sd32768;
   assign h3_round = i_h3_ff + 38'sd1;
   assign r_in = 37'(h3_round >>> 1);

   always_comb begin
      value_in = '0;
      sat_in = 1'b0;
      case (i_mode_ff)
         MODE_LINEAR: begin
            value_in = i_lin_ff;
         end
         MODE_SPLINE: begin
            if (r_in > 37'sd2147483647) begin
               value_in = 32'sh7FFFFFFF;
               sat_in = 1'b1;
            end else if (r_in < -37'sd2147483648) begin
               value_in = 32'sh80000000;
               sat_in = 1'b1;
            end else begin
               value_in = 32'(r_in);
            end
         end
         default: begin
            value_in = '0;
            sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_mode_ff <= mode;
         c_w_ff <= weight;
         c_a_ff <= 34'(e1 <<< 1);
         c_b_ff <= 33'(e2 - e0);
         c_c_ff <= c_c_in;
         c_d_ff <= c_d_in;
         c_diff_ff <= 33'(e1 - e0);
         c_base_ff <= p0;

         d_mode_ff <= c_mode_ff;
         d_w_ff <= c_w_ff;
         d_a_ff <= c_a_ff;
         d_b_ff <= c_b_ff;
         d_c_ff <= c_c_ff;
         d_base_ff <= c_base_ff;
         d_m1_ff <= 53'(c_d_ff) * 53'($signed({1'b0, c_w_ff}));
         d_ml_ff <= 51'(c_diff_ff) * 51'($signed({1'b0, c_w_ff}));

         e_mode_ff <= d_mode_ff;
         e_w_ff <= d_w_ff;
         e_a_ff <= d_a_ff;
         e_b_ff <= d_b_ff;
         e_h1_ff <= 37'(d_c_ff) + 37'(m1_round >>> 16);
         e_lin_ff <= 32'(d_base_ff + 32'(ml_round >>> 16));

         f_mode_ff <= e_mode_ff;
         f_w_ff <= e_w_ff;
         f_a_ff <= e_a_ff;
         f_b_ff <= e_b_ff;
         f_lin_ff <= e_lin_ff;
         f_m2_ff <= 55'(e_h1_ff) * 55'(ws);

         g_mode_ff <= f_mode_ff;
         g_w_ff <= f_w_ff;
         g_a_ff <= f_a_ff;
         g_lin_ff <= f_lin_ff;
         g_h2_ff <= 37'(f_b_ff) + 37'(m2_round >>> 16);

         h_mode_ff <= g_mode_ff;
         h_a_ff <= g_a_ff;
         h_lin_ff <= g_lin_ff;
         h_m3_ff <= 55'(g_h2_ff) * 55'($signed({1'b0, g_w_ff}));

         i_mode_ff <= h_mode_ff;
         i_lin_ff <= h_lin_ff;
         i_h3_ff <= 38'(h_a_ff) + 38'(m3_round >>> 16);

         value_ff <= value_in;
         sat_ff <= sat_in;
      end
   end

   assign ws = $signed({1'b0, e_w_ff});
   assign value = value_ff;
   assign sat = sat_ff;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench of the Catmull-Rom spline evaluator core.
`timescale 1ns / 1ps
module testbench;
   import ccr_pkg::*;

   localparam int NSLOTS = 16;
   localparam int LATENCY = 10;
   localparam longint LIMIT = 400000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_payload_type rsp_payload;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   req_payload_type pending_items[$];
   rsp_payload_type expected_points[$];
   point_type slot_points[NSLOTS];
   logic [4:0] count_setting;
   int send_idle_pct;
   int recv_idle_pct;
   logic req_took;
   logic hold_req;
   int hold_left;
   int mismatches;
   longint cycles = 0;

   catmull_rom_spline_eval_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic longint round16(longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic longint blend_axis(longint a, longint b, longint u);
      return round16(a * (65536 - u) + b * u);
   endfunction

   function automatic longint spline_axis(longint p0, longint p1, longint p2, longint p3,
                                          longint lt);
      longint h;
      h = -p0 + 3 * p1 - 3 * p2 + p3;
      h = (2 * p0 - 5 * p1 + 4 * p2 - p3) + round16(h * lt);
      h = (p2 - p0) + round16(h * lt);
      h = 2 * p1 + round16(h * lt);
      return (h + 1) >>> 1;
   endfunction

   function automatic longint axis_value(int axis, int n, int seg, longint u, longint lt);
      longint p[4];
      for (int k = 0; k < 4; k++) begin
         int s;
         s = (n == 2 || n == 3) ? k : seg + k;
         if (s >= NSLOTS) s = NSLOTS - 1;
         p[k] = axis == 0 ? longint'(slot_points[s].x) :
                axis == 1 ? longint'(slot_points[s].y) : longint'(slot_points[s].z);
      end
      if (n == 2) return blend_axis(p[0], p[1], u);
      if (n == 3) begin
         if (u < 32768) return blend_axis(p[0], p[1], 2 * u);
         return blend_axis(p[1], p[2], 2 * (u - 32768));
      end
      return spline_axis(p[0], p[1], p[2], p[3], lt);
   endfunction

   function automatic rsp_payload_type curve_point(longint position);
      rsp_payload_type r;
      longint u, s, lt, v;
      logic [31:0] c[3];
      int n, seg;
      r = '0;
      n = count_setting > NSLOTS ? NSLOTS : int'(count_setting);
      u = position > 65536 ? 65536 : position;
      if (n < 2) return r;
      seg = 0;
      lt = 0;
      if (n >= 4) begin
         s = u * (n - 3);
         if ((s >> 16) >= n - 3) begin
            seg = n - 4;
            lt = 65536;
         end else begin
            seg = int'(s >> 16);
            lt = s & 64'hFFFF;
         end
      end
      for (int a = 0; a < 3; a++) begin
         v = axis_value(a, n, seg, u, lt);
         if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            r.saturated = 1'b1;
         end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            r.saturated = 1'b1;
         end
         c[a] = v[31:0];
      end
      r.curve_x = c[0];
      r.curve_y = c[1];
      r.curve_z = c[2];
      return r;
   endfunction

   function automatic void add_item(req_payload_type it);
      pending_items.insert(pending_items.size(), it);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_payload);
            end else begin
               rsp_payload_type want;
               want = expected_points.pop_front();
               if (want.curve_x !== rsp_payload.curve_x ||
                   want.curve_y !== rsp_payload.curve_y ||
                   want.curve_z !== rsp_payload.curve_z ||
                   want.saturated !== rsp_payload.saturated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %0d %0d %0d sat %b, got %0d %0d %0d sat %b",
                        want.curve_x, want.curve_y, want.curve_z, want.saturated,
                        rsp_payload.curve_x, rsp_payload.curve_y, rsp_payload.curve_z,
                        rsp_payload.saturated);
               end
            end
         end
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            if (req_payload.kind == KIND_EVAL)
               expected_points.insert(expected_points.size(),
                                      curve_point(longint'(req_payload.position)));
            else begin
               slot_points[req_payload.point_index].x = req_payload.point_x;
               slot_points[req_payload.point_index].y = req_payload.point_y;
               slot_points[req_payload.point_index].z = req_payload.point_z;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_took)) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_req && hold_left == 0) hold_left <= 300;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      rsp_stall <= !reset && (hold_left > 0 || $urandom_range(99) < recv_idle_pct);
   end

   function automatic logic [31:0] random_coord();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_payload_type make_item(logic kind, logic [3:0] slot,
                                                 logic [16:0] position);
      req_payload_type it;
      it.kind = kind;
      it.point_index = slot;
      it.point_x = random_coord();
      it.point_y = random_coord();
      it.point_z = random_coord();
      it.position = position;
      return it;
   endfunction

   function automatic logic [16:0] random_position();
      if ($urandom_range(9) == 0) return 17'($urandom_range(0, 17'h1FFFF));
      if ($urandom_range(9) == 0) return $urandom_range(0, 1) ? ONE_Q16 : 17'd0;
      return 17'($urandom_range(0, 65536));
   endfunction

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || expected_points.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic set_point_count(logic [4:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(4 * REG_POINT_COUNT);
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      count_setting = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      logic [4:0] counts[10];
      req_payload_type it;
      counts = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd16, 5'd9, 5'd20, 5'd16};
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_took = 1'b0;
      hold_req = 1'b0;
      hold_left = 0;
      mismatches = 0;
      count_setting = '0;
      send_idle_pct = 13;
      recv_idle_pct = 57;
      for (int i = 0; i < NSLOTS; i++) slot_points[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every slot is written before any evaluation can read one.
      for (int i = 0; i < NSLOTS; i++) begin
         it = make_item(KIND_WRITE, 4'(i), 17'h1FFFF);
         if (i == 0) begin
            it.point_x = 32'h80000000; it.point_y = 32'h7FFFFFFF; it.point_z = 32'h0;
         end else if (i == 1) begin
            it.point_x = 32'h7FFFFFFF; it.point_y = 32'h80000000; it.point_z = 32'hFFFFFFFF;
         end
         add_item(it);
      end
      add_item(make_item(KIND_EVAL, 4'hF, 17'd0));
      add_item(make_item(KIND_EVAL, 4'h0, ONE_Q16));
      add_item(make_item(KIND_EVAL, 4'h5, 17'h1FFFF));
      wait_idle();
      set_point_count(5'd16);
      foreach (counts[k]) begin
         if (k == 0) add_item(make_item(KIND_EVAL, 4'h0, 17'h1FFFF));
         add_item(make_item(KIND_EVAL, 4'h0, 17'd0));
         add_item(make_item(KIND_EVAL, 4'h0, HALF_Q16 - 17'd1));
         add_item(make_item(KIND_EVAL, 4'h0, HALF_Q16));
         add_item(make_item(KIND_EVAL, 4'h0, ONE_Q16));
         wait_idle();
         set_point_count(counts[k]);
         if (k == 4) begin
            send_idle_pct = 57;
            recv_idle_pct = 13;
         end else if (k == 7) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int j = 0; j < 90; j++) begin
            if ($urandom_range(3) == 0)
               add_item(make_item(KIND_WRITE, 4'($urandom_range(15)), 17'($urandom())));
            else
               add_item(make_item(KIND_EVAL, 4'($urandom_range(15)), random_position()));
            if (j == 45) begin
               if (k == 2 || k == 8) begin
                  hold_req = 1'b1;
                  @(negedge clock);
                  @(negedge clock);
                  hold_req = 1'b0;
               end else if (k == 5) begin
                  while (pending_items.size() > 0 || req_valid ||
                         expected_points.size() > 0)
                     @(posedge clock);
               end
            end
         end
      end
      wait_idle();
      if (mismatches == 0 && expected_points.size() == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule
